// ===== hw/rtl/sge_pkg.sv =====
`default_nettype none

package sge_pkg;

  // Width of the frame offset counter; it saturates at its all-ones value.
  localparam int unsigned POS_W = 17;
  // Width used for offset sums, one bit wider than the offset counter.
  localparam int unsigned SUM_W = POS_W + 1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Smallest legal IPv4 header length and TCP data offset, in 32-bit words.
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  // Byte offsets inside the TCP header.
  localparam int unsigned TCP_SRC_HI = 0;
  localparam int unsigned TCP_SRC_LO = 1;
  localparam int unsigned TCP_DST_HI = 2;
  localparam int unsigned TCP_DST_LO = 3;
  localparam int unsigned TCP_DOFF   = 12;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAIL_PORT_A   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAIL_PORT_B   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAIL_PORT_C   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREETING_WORD = 2'd3;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [15:0] MAIL_PORT_A_RST   = 16'd25;
  localparam logic [15:0] MAIL_PORT_B_RST   = 16'd465;
  localparam logic [15:0] MAIL_PORT_C_RST   = 16'd587;
  localparam logic [31:0] GREETING_WORD_RST = 32'h45484C4F;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_GREETING = 2'd1,
    PH_EMIT     = 2'd2,
    PH_SKIP     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } sge_in_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       message_last;
    logic       cut_short;
  } sge_out_t;

  typedef struct packed {
    logic [15:0] mail_port_a;
    logic [15:0] mail_port_b;
    logic [15:0] mail_port_c;
    logic [31:0] greeting_word;
  } sge_cfg_t;

  function automatic logic is_mail_port(input sge_cfg_t cfg, input logic [15:0] port);
    is_mail_port = (port == cfg.mail_port_a) || (port == cfg.mail_port_b) ||
                   (port == cfg.mail_port_c);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sge_front.sv =====
`default_nettype none

module sge_front #(
  parameter int unsigned ETH_HEADER_BYTES = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sge_pkg::sge_in_t in_data,
  input  wire sge_pkg::sge_cfg_t cfg,
  input  wire logic             space,
  output logic                  push,
  output sge_pkg::sge_out_t     push_data
);

  localparam int unsigned SW = sge_pkg::SUM_W;
  localparam logic [SW-1:0] E_OFF  = SW'(ETH_HEADER_BYTES);
  localparam logic [SW-1:0] E_LEN0 = E_OFF + SW'(2);
  localparam logic [SW-1:0] E_LEN1 = E_OFF + SW'(3);

  sge_pkg::phase_t                phase, phase_next;
  logic [sge_pkg::POS_W-1:0]      byte_position, byte_position_next;
  logic [3:0]                     ip_header_words, ip_header_words_next;
  logic [15:0]                    ip_total_length, ip_total_length_next;
  logic [3:0]                     tcp_header_words, tcp_header_words_next;
  logic [15:0]                    source_port, source_port_next;
  logic [15:0]                    dest_port, dest_port_next;
  logic [31:0]                    greeting_shift, greeting_shift_next;

  logic          accept;
  logic [7:0]    b;
  logic [SW-1:0] p, p1, ip_len, tcp_len, tcp_start, pay_start, ip_end, off, total;
  logic [31:0]   shifted;
  logic          at_end;

  assign in_ready = space;
  assign accept   = in_valid && space;
  assign b        = in_data.frame_byte;

  assign p         = {1'b0, byte_position};
  assign p1        = p + SW'(1);
  assign ip_len    = SW'({ip_header_words, 2'b00});
  assign tcp_len   = SW'({tcp_header_words, 2'b00});
  assign tcp_start = E_OFF + ip_len;
  assign pay_start = tcp_start + tcp_len;
  assign total     = SW'(ip_total_length);
  assign ip_end    = E_OFF + total;
  assign off       = p - tcp_start;
  assign shifted   = {greeting_shift[23:0], b};
  assign at_end    = (p1 >= ip_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= sge_pkg::PH_HEADER;
      byte_position    <= '0;
      ip_header_words  <= '0;
      ip_total_length  <= '0;
      tcp_header_words <= '0;
      source_port      <= '0;
      dest_port        <= '0;
      greeting_shift   <= '0;
    end else begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      ip_header_words  <= ip_header_words_next;
      ip_total_length  <= ip_total_length_next;
      tcp_header_words <= tcp_header_words_next;
      source_port      <= source_port_next;
      dest_port        <= dest_port_next;
      greeting_shift   <= greeting_shift_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    ip_header_words_next  = ip_header_words;
    ip_total_length_next  = ip_total_length;
    tcp_header_words_next = tcp_header_words;
    source_port_next      = source_port;
    dest_port_next        = dest_port;
    greeting_shift_next   = greeting_shift;
    push                  = 1'b0;
    push_data             = '0;

    if (accept) begin
      case (phase)
        sge_pkg::PH_HEADER: begin
          if (p == E_OFF) begin
            ip_header_words_next = b[3:0];
            if (b[3:0] < sge_pkg::MIN_HDR_WORDS) begin
              phase_next = sge_pkg::PH_SKIP;
            end
          end else if (p == E_LEN0) begin
            ip_total_length_next = {b, ip_total_length[7:0]};
          end else if (p == E_LEN1) begin
            ip_total_length_next = {ip_total_length[15:8], b};
          end else if (p > E_LEN1 && p >= tcp_start) begin
            if (off == SW'(sge_pkg::TCP_SRC_HI)) begin
              source_port_next = {b, source_port[7:0]};
            end else if (off == SW'(sge_pkg::TCP_SRC_LO)) begin
              source_port_next = {source_port[15:8], b};
            end else if (off == SW'(sge_pkg::TCP_DST_HI)) begin
              dest_port_next = {b, dest_port[7:0]};
            end else if (off == SW'(sge_pkg::TCP_DST_LO)) begin
              dest_port_next = {dest_port[15:8], b};
            end else if (off == SW'(sge_pkg::TCP_DOFF)) begin
              tcp_header_words_next = b[7:4];
              if (b[7:4] < sge_pkg::MIN_HDR_WORDS) begin
                phase_next = sge_pkg::PH_SKIP;
              end
            end
            // The last TCP header byte decides whether the payload is looked at.
            if (off > SW'(sge_pkg::TCP_DOFF) && p1 == pay_start) begin
              greeting_shift_next = '0;
              if (total >= ip_len + tcp_len + SW'(4) &&
                  (sge_pkg::is_mail_port(cfg, source_port) ||
                   sge_pkg::is_mail_port(cfg, dest_port))) begin
                phase_next = sge_pkg::PH_GREETING;
              end else begin
                phase_next = sge_pkg::PH_SKIP;
              end
            end
          end
        end
        sge_pkg::PH_GREETING: begin
          greeting_shift_next = shifted;
          if (p == pay_start + SW'(3)) begin
            if (shifted == cfg.greeting_word && p1 < ip_end) begin
              phase_next = sge_pkg::PH_EMIT;
            end else begin
              phase_next = sge_pkg::PH_SKIP;
            end
          end
        end
        sge_pkg::PH_EMIT: begin
          push                   = 1'b1;
          push_data.text_byte    = b;
          push_data.message_last = at_end || in_data.frame_last;
          push_data.cut_short    = !at_end && in_data.frame_last;
          if (at_end) begin
            phase_next = sge_pkg::PH_SKIP;
          end
        end
        default: begin
        end
      endcase

      if (byte_position != sge_pkg::POS_MAX) begin
        byte_position_next = byte_position + sge_pkg::POS_W'(1);
      end

      if (in_data.frame_last) begin
        phase_next            = sge_pkg::PH_HEADER;
        byte_position_next    = '0;
        ip_header_words_next  = '0;
        ip_total_length_next  = '0;
        tcp_header_words_next = '0;
        source_port_next      = '0;
        dest_port_next        = '0;
        greeting_shift_next   = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sge_queue.sv =====
`default_nettype none

module sge_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sge_pkg::sge_out_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sge_pkg::sge_out_t      out_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  sge_pkg::sge_out_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop, do_push;

  assign space     = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign do_push   = push && space;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/smtp_greeting_extractor_core.sv =====
// Each text beat is pushed into the result queue as its frame beat is accepted.
// Throughput: one frame beat per cycle, sustained while the output side keeps up; the
// front parser stalls only when the result queue between the parser and the output is full.
// Reset: rst is synchronous and active high; it returns the parser to header parsing,
// empties the result queue and restores the mail ports and greeting word to their defaults.
`default_nettype none

module smtp_greeting_extractor_core #(
  parameter int unsigned ETH_HEADER_BYTES = 14,
  parameter int unsigned QUEUE_DEPTH      = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire sge_pkg::sge_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output sge_pkg::sge_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [sge_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sge_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers. The user must see they are only written while the block is idle,
  // so the parser sees stable values for the whole of every frame. The block never checks it.
  sge_pkg::sge_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mail_port_a   <= sge_pkg::MAIL_PORT_A_RST;
      cfg.mail_port_b   <= sge_pkg::MAIL_PORT_B_RST;
      cfg.mail_port_c   <= sge_pkg::MAIL_PORT_C_RST;
      cfg.greeting_word <= sge_pkg::GREETING_WORD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sge_pkg::REG_MAIL_PORT_A:   cfg.mail_port_a   <= cfg_data[15:0];
        sge_pkg::REG_MAIL_PORT_B:   cfg.mail_port_b   <= cfg_data[15:0];
        sge_pkg::REG_MAIL_PORT_C:   cfg.mail_port_c   <= cfg_data[15:0];
        sge_pkg::REG_GREETING_WORD: cfg.greeting_word <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front parser walks the Ethernet, IPv4 and TCP headers one beat at a
  // time, checks the ports and the greeting word, and hands each payload byte
  // that follows a matching greeting to the queue as a finished result.
  logic              space;
  logic              push;
  sge_pkg::sge_out_t push_data;

  sge_front #(
    .ETH_HEADER_BYTES(ETH_HEADER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .space    (space),
    .push     (push),
    .push_data(push_data)
  );

  // The queue is the back end: its head drives the output directly, so a
  // stalled consumer never holds up the parser until the queue fills.
  sge_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sge_checker.sv =====
`default_nettype none

module sge_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire sge_pkg::sge_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire sge_pkg::sge_out_t out_data
);

  // A stalled text beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // A truncated message always ends on that beat.
  a_cut_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.cut_short |-> out_data.message_last)
    else $error("cut_short without message_last");

  // Back pressure on the input only arises from results waiting on the output.
  a_stall_has_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Nothing is emitted without an input beat accepted in the previous cycle or data already queued.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("output beat appeared without an input beat");

endmodule

bind smtp_greeting_extractor_core sge_checker u_sge_checker (.*);

`default_nettype wire

// ===== bench/smtp_greeting_extractor_core_tb.sv =====
`default_nettype none

// Self-checking bench for the mail greeting extractor. Whole Ethernet/IPv4/TCP
// frames are built from a small descriptor and pushed into the core one byte
// per beat. Every accepted byte also runs through a software copy of the
// parser below, which keeps its own frame state and register copy and queues
// the text beat that the core should produce. A monitor pops that queue on
// every accepted output beat and compares it field by field.
module smtp_greeting_extractor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ETH_BYTES = 14;
  // Each text beat passes through the four-entry result queue on its way out,
  // so a short pause is enough to be sure the core has gone quiet.
  localparam int unsigned SETTLE_CYCLES = 8;

  // One frame as the generator sees it. The length is the number of bytes
  // actually sent, so it can end before or after the IP total length.
  typedef struct {
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] tot_len;
    logic [31:0] greet;
    int unsigned len;
  } frame_desc_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  sge_pkg::sge_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  sge_pkg::sge_out_t out_data;
  logic              cfg_we;
  logic [sge_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sge_pkg::CFG_DATA_W-1:0] cfg_data;

  smtp_greeting_extractor_core #(
    .ETH_HEADER_BYTES(ETH_BYTES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Text beats the core owes us, oldest first.
  sge_pkg::sge_out_t pending_text[$];
  sge_pkg::sge_out_t text_want;

  // Bench copy of the registers and of the per-frame parse state.
  sge_pkg::sge_cfg_t cfg_now;
  int unsigned       pos_now;
  logic [3:0]        ihl_now;
  logic [15:0]       tot_len_now;
  logic [3:0]        doff_now;
  logic [15:0]       sport_now;
  logic [15:0]       dport_now;
  logic [31:0]       greet_shift_now;
  sge_pkg::phase_t   phase_now;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned frames_sent;
  int unsigned texts_checked;
  int unsigned reg_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit. One millisecond is many times what about a thousand beats need,
  // even if each of them owes a text beat behind a receiver that idles most
  // of the time.
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void clear_frame_state();
    pos_now         = 0;
    ihl_now         = '0;
    tot_len_now     = '0;
    doff_now        = '0;
    sport_now       = '0;
    dport_now       = '0;
    greet_shift_now = '0;
    phase_now       = sge_pkg::PH_HEADER;
  endfunction

  function automatic logic port_is_mail(input logic [15:0] port);
    return port == cfg_now.mail_port_a || port == cfg_now.mail_port_b ||
           port == cfg_now.mail_port_c;
  endfunction

  // Advances the bench parser by one frame byte and queues the text beat it
  // yields, if any. All offsets are taken from the state before this byte.
  function automatic void parse_frame_byte(input logic [7:0] b, input logic last);
    int unsigned       p;
    int unsigned       ip_len;
    int unsigned       tcp0;
    int unsigned       pay0;
    int unsigned       ip_end;
    int unsigned       off;
    int unsigned       hdrs;
    logic              at_end;
    logic              mail_ok;
    sge_pkg::sge_out_t r;
    p      = pos_now;
    ip_len = 4 * ihl_now;
    tcp0   = ETH_BYTES + ip_len;
    pay0   = tcp0 + 4 * doff_now;
    ip_end = ETH_BYTES + tot_len_now;
    case (phase_now)
      sge_pkg::PH_HEADER: begin
        if (p == ETH_BYTES) begin
          ihl_now = b[3:0];
          if (ihl_now < sge_pkg::MIN_HDR_WORDS) phase_now = sge_pkg::PH_SKIP;
        end else if (p == ETH_BYTES + 2) begin
          tot_len_now[15:8] = b;
        end else if (p == ETH_BYTES + 3) begin
          tot_len_now[7:0] = b;
        end else if (p > ETH_BYTES + 3 && p >= tcp0) begin
          off = p - tcp0;
          if (off == sge_pkg::TCP_SRC_HI) sport_now[15:8] = b;
          else if (off == sge_pkg::TCP_SRC_LO) sport_now[7:0] = b;
          else if (off == sge_pkg::TCP_DST_HI) dport_now[15:8] = b;
          else if (off == sge_pkg::TCP_DST_LO) dport_now[7:0] = b;
          else if (off == sge_pkg::TCP_DOFF) begin
            doff_now = b[7:4];
            if (doff_now < sge_pkg::MIN_HDR_WORDS) phase_now = sge_pkg::PH_SKIP;
          end
          // The port and length decision falls on the last TCP header byte.
          if (phase_now == sge_pkg::PH_HEADER && off > sge_pkg::TCP_DOFF) begin
            hdrs = ip_len + 4 * doff_now;
            if (p + 1 == tcp0 + 4 * doff_now) begin
              mail_ok = tot_len_now >= hdrs + 4 &&
                        (port_is_mail(sport_now) || port_is_mail(dport_now));
              phase_now = mail_ok ? sge_pkg::PH_GREETING : sge_pkg::PH_SKIP;
              greet_shift_now = '0;
            end
          end
        end
      end
      sge_pkg::PH_GREETING: begin
        greet_shift_now = {greet_shift_now[23:0], b};
        if (p == pay0 + 3) begin
          // A greeting that fills the payload exactly leaves nothing to emit.
          if (greet_shift_now == cfg_now.greeting_word && p + 1 < ip_end)
            phase_now = sge_pkg::PH_EMIT;
          else
            phase_now = sge_pkg::PH_SKIP;
        end
      end
      sge_pkg::PH_EMIT: begin
        at_end = (p + 1 >= ip_end);
        r.text_byte    = b;
        r.message_last = at_end || last;
        r.cut_short    = !at_end && last;
        pending_text.push_back(r);
        if (at_end) phase_now = sge_pkg::PH_SKIP;
      end
      default: begin
      end
    endcase
    if (pos_now < sge_pkg::POS_MAX) pos_now++;
    if (last) clear_frame_state();
  endfunction

  // Offers one frame byte, holding it until the core takes it. Random idle
  // cycles are inserted ahead of the beat at the current sender rate.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{frame_byte: b, frame_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_frame_byte(b, last);
    beats_sent++;
  endtask

  // Builds the frame byte by byte: header fields at their offsets, the
  // greeting candidate in the first four payload bytes, random filler elsewhere.
  task automatic send_frame(input frame_desc_t f);
    int unsigned tcp0;
    int unsigned pay0;
    logic [7:0]  b;
    tcp0 = ETH_BYTES + 4 * f.ihl;
    pay0 = tcp0 + 4 * f.doff;
    for (int unsigned i = 0; i < f.len; i++) begin
      b = 8'($urandom_range(255));
      if (i == ETH_BYTES) b[3:0] = f.ihl;
      else if (i == ETH_BYTES + 2) b = f.tot_len[15:8];
      else if (i == ETH_BYTES + 3) b = f.tot_len[7:0];
      else if (i > ETH_BYTES + 3 && i >= tcp0) begin
        if (i == tcp0 + sge_pkg::TCP_SRC_HI) b = f.sport[15:8];
        else if (i == tcp0 + sge_pkg::TCP_SRC_LO) b = f.sport[7:0];
        else if (i == tcp0 + sge_pkg::TCP_DST_HI) b = f.dport[15:8];
        else if (i == tcp0 + sge_pkg::TCP_DST_LO) b = f.dport[7:0];
        else if (i == tcp0 + sge_pkg::TCP_DOFF) b[7:4] = f.doff;
        else if (i >= pay0 && i < pay0 + 4 && f.doff >= sge_pkg::MIN_HDR_WORDS)
          b = f.greet[8 * (3 - (i - pay0)) +: 8];
      end
      send_beat(b, i == f.len - 1);
    end
    frames_sent++;
  endtask

  // A well-formed frame whose IP total length covers exactly the headers and
  // pay_len payload bytes, followed by extra bytes of link padding.
  function automatic frame_desc_t make_frame(input logic [3:0] ihl, input logic [3:0] doff,
                                             input logic [15:0] sport,
                                             input logic [15:0] dport,
                                             input int unsigned pay_len,
                                             input logic [31:0] greet,
                                             input int unsigned extra);
    frame_desc_t f;
    int unsigned tot;
    tot       = 4 * ihl + 4 * doff + pay_len;
    f.ihl     = ihl;
    f.doff    = doff;
    f.sport   = sport;
    f.dport   = dport;
    f.tot_len = 16'(tot);
    f.greet   = greet;
    f.len     = ETH_BYTES + tot + extra;
    return f;
  endfunction

  // Stops offering input and waits until the core has delivered everything
  // queued, then gives it a settling pause in case a frame produced nothing.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back, only once the core is idle.
  task automatic program_regs(input sge_pkg::sge_cfg_t c);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= sge_pkg::REG_MAIL_PORT_A;
    cfg_data  <= {16'h0000, c.mail_port_a};
    @(posedge clk);
    cfg_index <= sge_pkg::REG_MAIL_PORT_B;
    cfg_data  <= {16'h0000, c.mail_port_b};
    @(posedge clk);
    cfg_index <= sge_pkg::REG_MAIL_PORT_C;
    cfg_data  <= {16'h0000, c.mail_port_c};
    @(posedge clk);
    cfg_index <= sge_pkg::REG_GREETING_WORD;
    cfg_data  <= c.greeting_word;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cfg_now  = c;
    reg_settings++;
  endtask

  function automatic logic [15:0] pick_port(input logic [15:0] dflt);
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(65535));
      default: return dflt;
    endcase
  endfunction

  function automatic sge_pkg::sge_cfg_t random_cfg();
    sge_pkg::sge_cfg_t c;
    c.mail_port_a = pick_port(sge_pkg::MAIL_PORT_A_RST);
    c.mail_port_b = pick_port(sge_pkg::MAIL_PORT_B_RST);
    c.mail_port_c = pick_port(sge_pkg::MAIL_PORT_C_RST);
    case ($urandom_range(9))
      0:       c.greeting_word = 32'h0000_0000;
      1:       c.greeting_word = 32'hFFFF_FFFF;
      2, 3, 4: c.greeting_word = $urandom;
      default: c.greeting_word = sge_pkg::GREETING_WORD_RST;
    endcase
    return c;
  endfunction

  // Mostly mail frames with random content, so that most of them reach the
  // greeting compare and the emit phase. The rest are off-port frames, bad
  // greetings, bad header lengths, odd total lengths, truncations and noise.
  function automatic frame_desc_t random_frame();
    frame_desc_t f;
    logic [15:0] port;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [31:0] greet;
    int unsigned pay_len;
    case ($urandom_range(2))
      0:       port = cfg_now.mail_port_a;
      1:       port = cfg_now.mail_port_b;
      default: port = cfg_now.mail_port_c;
    endcase
    sport = 16'($urandom_range(65535));
    dport = 16'($urandom_range(65535));
    if ($urandom_range(99) < 80) begin
      if ($urandom_range(1)) sport = port;
      else dport = port;
    end
    ihl   = ($urandom_range(99) < 85) ? 4'd5 : 4'($urandom_range(15));
    doff  = ($urandom_range(99) < 85) ? 4'd5 : 4'($urandom_range(15));
    pay_len = ($urandom_range(99) < 15) ? $urandom_range(0, 4) : $urandom_range(5, 24);
    greet = cfg_now.greeting_word;
    if ($urandom_range(99) < 20) greet = greet ^ (32'h1 << $urandom_range(31));
    f = make_frame(ihl, doff, sport, dport, pay_len, greet,
                   $urandom_range(1) ? 0 : $urandom_range(1, 4));
    if ($urandom_range(99) < 10) f.tot_len = 16'($urandom_range(65535));
    if ($urandom_range(99) < 12) f.len = $urandom_range(1, f.len);
    // Pure noise: header lengths, total length and greeting random, and a random length.
    if ($urandom_range(99) < 8) begin
      f.ihl     = 4'($urandom_range(15));
      f.doff    = 4'($urandom_range(15));
      f.tot_len = 16'($urandom_range(65535));
      f.greet   = $urandom;
      f.len     = $urandom_range(1, 80);
    end
    return f;
  endfunction

  // Hand-picked frames under the reset register values: the main paths
  // through the parser and the corner cases at frame and payload boundaries.
  task automatic test_directed_frames();
    frame_desc_t f;
    // Destination port match, clean extraction, then source port match with
    // link padding beyond the IP total length that must be ignored.
    send_frame(make_frame(4'd5, 4'd5, 16'd1234, sge_pkg::MAIL_PORT_A_RST, 10,
                          sge_pkg::GREETING_WORD_RST, 0));
    send_frame(make_frame(4'd5, 4'd5, sge_pkg::MAIL_PORT_B_RST, 16'd80, 12,
                          sge_pkg::GREETING_WORD_RST, 5));
    // Header lengths below five words are rejected.
    send_frame(make_frame(4'd4, 4'd5, 16'd1, sge_pkg::MAIL_PORT_A_RST, 10,
                          sge_pkg::GREETING_WORD_RST, 0));
    send_frame(make_frame(4'd5, 4'd4, 16'd1, sge_pkg::MAIL_PORT_A_RST, 10,
                          sge_pkg::GREETING_WORD_RST, 0));
    // A payload of exactly the greeting emits nothing.
    send_frame(make_frame(4'd5, 4'd5, 16'd1, sge_pkg::MAIL_PORT_A_RST, 4,
                          sge_pkg::GREETING_WORD_RST, 2));
    // Frame ends during extraction: total length claims far more data.
    f = make_frame(4'd5, 4'd5, sge_pkg::MAIL_PORT_A_RST, sge_pkg::MAIL_PORT_A_RST, 10,
                   sge_pkg::GREETING_WORD_RST, 0);
    f.tot_len = 16'hFFFF;
    send_frame(f);
    // Frame ends inside the greeting, then a one-byte frame.
    f = make_frame(4'd5, 4'd5, 16'd1, sge_pkg::MAIL_PORT_A_RST, 10,
                   sge_pkg::GREETING_WORD_RST, 0);
    f.len = ETH_BYTES + 40 + 2;
    send_frame(f);
    f.len = 1;
    send_frame(f);
    // Total length shorter than the headers.
    f = make_frame(4'd5, 4'd5, 16'd1, sge_pkg::MAIL_PORT_A_RST, 10,
                   sge_pkg::GREETING_WORD_RST, 0);
    f.tot_len = 16'd30;
    send_frame(f);
  endtask

  // Register extremes: ports at zero and all ones, greeting all zeros and
  // all ones, and a check that the old defaults no longer match.
  task automatic test_port_config();
    program_regs('{mail_port_a: 16'h0000, mail_port_b: 16'hFFFF, mail_port_c: 16'hABCD,
                   greeting_word: 32'h0000_0000});
    send_frame(make_frame(4'd5, 4'd5, 16'h0000, 16'd9, 8, 32'h0000_0000, 0));
    send_frame(make_frame(4'd5, 4'd5, 16'd9, 16'hFFFF, 8, 32'h0000_0000, 0));
    send_frame(make_frame(4'd5, 4'd5, 16'd9, sge_pkg::MAIL_PORT_A_RST, 8,
                          32'h0000_0000, 0));
    program_regs('{mail_port_a: 16'hFFFF, mail_port_b: 16'h0000, mail_port_c: 16'h5432,
                   greeting_word: 32'hFFFF_FFFF});
    send_frame(make_frame(4'd5, 4'd5, 16'h5432, 16'h5432, 9, 32'hFFFF_FFFF, 0));
    send_frame(make_frame(4'd5, 4'd5, 16'd3, 16'h0000, 9, 32'hFFFF_FFFE, 0));
  endtask

  // Random frames under a given idle mix, with a fresh register setting
  // every few frames.
  task automatic test_random_traffic(input int unsigned snd_pct,
                                     input int unsigned rcv_pct,
                                     input int unsigned beat_budget);
    int unsigned start;
    int unsigned nframes;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start   = beats_sent;
    nframes = 0;
    while (beats_sent - start < beat_budget) begin
      if (nframes % 6 == 0) program_regs(random_cfg());
      send_frame(random_frame());
      nframes++;
    end
    settle_block();
  endtask

  // The output side stalls at random at the current receiver rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Scoreboard: every accepted text beat is matched against the oldest one
  // the bench parser queued.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_text.size() == 0) begin
        $error("unexpected text beat: text_byte %02h message_last %0b cut_short %0b",
               out_data.text_byte, out_data.message_last, out_data.cut_short);
        mismatches++;
      end else begin
        text_want = pending_text.pop_front();
        if (out_data.text_byte !== text_want.text_byte) begin
          $error("text_byte: expected %02h, got %02h",
                 text_want.text_byte, out_data.text_byte);
          mismatches++;
        end
        if (out_data.message_last !== text_want.message_last) begin
          $error("message_last: expected %0b, got %0b",
                 text_want.message_last, out_data.message_last);
          mismatches++;
        end
        if (out_data.cut_short !== text_want.cut_short) begin
          $error("cut_short: expected %0b, got %0b",
                 text_want.cut_short, out_data.cut_short);
          mismatches++;
        end
      end
      texts_checked++;
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= sge_pkg::REG_MAIL_PORT_A;
    cfg_data  <= '0;
    cfg_now.mail_port_a   = sge_pkg::MAIL_PORT_A_RST;
    cfg_now.mail_port_b   = sge_pkg::MAIL_PORT_B_RST;
    cfg_now.mail_port_c   = sge_pkg::MAIL_PORT_C_RST;
    cfg_now.greeting_word = sge_pkg::GREETING_WORD_RST;
    clear_frame_state();
    mismatches    = 0;
    beats_sent    = 0;
    frames_sent   = 0;
    texts_checked = 0;
    reg_settings  = 0;
    // The first idle mix, a mostly stalled receiver, covers the directed part.
    send_idle_pct = 8;
    recv_idle_pct = 83;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_port_config();
    test_random_traffic(8, 83, 40);
    test_random_traffic(83, 8, 40);
    test_random_traffic(0, 0, 40);
    settle_block();

    $display("Sent %0d frames in %0d beats and checked %0d text beats,",
             frames_sent, beats_sent, texts_checked);
    $display("over %0d register settings and three sender/receiver stall mixes.",
             reg_settings);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
